// ----- rtl/cse_pkg.sv -----
// shared types, codes and saturation helpers for the chebyshev series evaluator
`default_nettype none

package cse_pkg;

  // data word and wide intermediate widths
  localparam int WORD_W = 32;
  localparam int WIDE_W = 66;

  // item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SPAN = 1'b1;

  // register reset values
  localparam logic signed [WORD_W-1:0] INTERVAL_SUM_RST = 32'sd0;
  localparam logic signed [WORD_W-1:0] INVERSE_SPAN_RST = 32'sd32768;

  // input item
  typedef struct packed {
    logic                     operation;
    logic [3:0]               coef_index;
    logic signed [WORD_W-1:0] coef_value;
    logic signed [WORD_W-1:0] argument;
    logic [4:0]               term_count;
  } cse_request_t;

  // result item
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     saturated;
  } cse_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_coef;
    logic start_eval;
    logic zero_result;
    logic map_mul;
    logic map_y;
    logic term_mul;
    logic term_acc;
  } cse_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_term;
  } cse_status_t;

  // true when a wide value leaves the signed word range
  function automatic logic out_of_range(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = WIDE_W'(32'sh80000000);
    return (v > hi) || (v < lo);
  endfunction

  // clamp a wide value to the signed word range
  function automatic logic signed [WORD_W-1:0] clamp_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = WIDE_W'(32'sh80000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cse_datapath.sv -----
// datapath: registers, coefficient memory, multiplier and clenshaw accumulate
`default_nettype none

module cse_datapath #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [cse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [cse_pkg::WORD_W-1:0]    cfg_data,
  input  wire cse_pkg::cse_request_t   request,
  input  wire cse_pkg::cse_cmd_t       cmd,
  output cse_pkg::cse_status_t         status,
  output cse_pkg::cse_result_t         result
);
  import cse_pkg::*;

  localparam int TIDX = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic signed [2*WORD_W-1:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // configuration registers
  logic signed [WORD_W-1:0] interval_sum;
  logic signed [WORD_W-1:0] inverse_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_sum <= INTERVAL_SUM_RST;
      inverse_span <= INVERSE_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_SUM: interval_sum <= $signed(cfg_data);
        REG_INVERSE_SPAN: inverse_span <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // coefficient memory with registered read
  logic [WORD_W-1:0] coef_mem [MAX_TERMS];
  logic [WORD_W-1:0] coef_rd;
  logic [TIDX-1:0]   term_idx;
  logic              load_in_range;

  assign load_in_range = 32'(request.coef_index) < 32'(MAX_TERMS);

  always_ff @(posedge clk) begin
    if (cmd.load_coef && load_in_range) begin
      coef_mem[TIDX'(request.coef_index)] <= request.coef_value;
    end
    coef_rd <= coef_mem[term_idx];
  end

  // argument mapping: t = sat(2x - interval_sum)
  logic signed [WIDE_W-1:0] t_wide;
  assign t_wide = (WIDE_W'(request.argument) <<< 1) - WIDE_W'(interval_sum);

  // first term index from the clamped term count
  logic [TIDX-1:0] first_idx;
  always_comb begin
    if (32'(request.term_count) > 32'(MAX_TERMS)) begin
      first_idx = TIDX'(MAX_TERMS - 1);
    end else begin
      first_idx = TIDX'(32'(request.term_count) - 32'd1);
    end
  end

  // working registers
  logic signed [WORD_W-1:0]   mul_a;
  logic signed [WORD_W-1:0]   y;
  logic signed [WORD_W-1:0]   y2;
  logic signed [WORD_W-1:0]   d;
  logic signed [WORD_W-1:0]   dd;
  logic signed [2*WORD_W-1:0] prod;
  logic                       flag;

  // rounded product: ties toward plus infinity
  logic signed [2*WORD_W-1:0] prod_rnd;
  assign prod_rnd = (prod + HALF) >>> FRAC_BITS;

  // y and 2y from the mapping product
  logic signed [WORD_W-1:0] y_sat;
  logic signed [WIDE_W-1:0] y2_wide;
  logic                     y_ovf;
  assign y_ovf   = out_of_range(WIDE_W'(prod_rnd));
  assign y_sat   = clamp_word(WIDE_W'(prod_rnd));
  assign y2_wide = WIDE_W'(y_sat) <<< 1;

  // clenshaw step: rnd(p) - dd + c, coefficient zero enters halved
  logic signed [WORD_W-1:0] coef_term;
  logic signed [WIDE_W-1:0] acc_wide;
  logic signed [WORD_W-1:0] acc_sat;
  logic                     acc_ovf;
  assign coef_term = status.last_term ? ($signed(coef_rd) >>> 1) : $signed(coef_rd);
  assign acc_wide  = WIDE_W'(prod_rnd) - WIDE_W'(dd) + WIDE_W'(coef_term);
  assign acc_sat   = clamp_word(acc_wide);
  assign acc_ovf   = out_of_range(acc_wide);

  assign status.last_term = (term_idx == '0);

  // sequenced datapath registers
  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      mul_a    <= clamp_word(t_wide);
      flag     <= out_of_range(t_wide);
      term_idx <= first_idx;
    end
    if (cmd.map_mul) begin
      prod <= mul_a * inverse_span;
    end
    if (cmd.map_y) begin
      y    <= y_sat;
      y2   <= clamp_word(y2_wide);
      flag <= flag | y_ovf | out_of_range(y2_wide);
      d    <= '0;
      dd   <= '0;
    end
    if (cmd.term_mul) begin
      prod <= (status.last_term ? y : y2) * d;
    end
    if (cmd.term_acc) begin
      d    <= acc_sat;
      dd   <= d;
      flag <= flag | acc_ovf;
      if (status.last_term) begin
        result.value     <= acc_sat;
        result.saturated <= flag | acc_ovf;
      end else begin
        term_idx <= term_idx - TIDX'(1);
      end
    end
    if (cmd.zero_result) begin
      result.value     <= '0;
      result.saturated <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cse_controller.sv -----
// controller: issues load and zero-result commands, sequences argument mapping and one multiply-accumulate per term
`default_nettype none

module cse_controller (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire                         operation,
  input  wire                         zero_count,
  input  wire cse_pkg::cse_status_t   status,
  output cse_pkg::cse_cmd_t           cmd,
  output logic                        busy,
  output logic                        done
);
  import cse_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAP_MUL  = 3'd1;
  localparam logic [2:0] ST_MAP_Y    = 3'd2;
  localparam logic [2:0] ST_TERM_MUL = 3'd3;
  localparam logic [2:0] ST_TERM_ACC = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            cmd.load_coef = 1'b1;
          end else if (zero_count) begin
            cmd.zero_result = 1'b1;
            done_next       = 1'b1;
          end else begin
            cmd.start_eval = 1'b1;
            state_next     = ST_MAP_MUL;
          end
        end
      end
      ST_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        cmd.map_y  = 1'b1;
        state_next = ST_TERM_MUL;
      end
      ST_TERM_MUL: begin
        cmd.term_mul = 1'b1;
        state_next   = ST_TERM_ACC;
      end
      ST_TERM_ACC: begin
        cmd.term_acc = 1'b1;
        if (status.last_term) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_TERM_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/chebyshev_series_evaluator_top.sv -----
// Chebyshev series evaluator: load items fill the table, eval items give one result
// Load: the table is written on accept, busy stays low, no result. Eval with m = min(term_count, MAX_TERMS):
// done rises, registered from the last accumulate state, and busy is low again in that cycle; an eval
// item runs two mapping states, then a multiply and an accumulate state per term, and busy holds off a new item.
// Eval with term_count zero: result in the next cycle, one item per cycle.
// Synchronous reset idles the sequencer and restores config; the table keeps its contents.
`default_nettype none

module chebyshev_series_evaluator_top #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [cse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [cse_pkg::WORD_W-1:0]    cfg_data,
  input  wire                          start,
  input  wire cse_pkg::cse_request_t   request,
  output logic                         busy,
  output logic                         done,
  output cse_pkg::cse_result_t         result
);
  import cse_pkg::*;

  cse_cmd_t    cmd;
  cse_status_t status;

  // sequencer
  cse_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (request.operation),
    .zero_count (request.term_count == 5'd0),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  // arithmetic and storage
  cse_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire
